@@ sv/a2p_pkg.sv @@
package a2p_pkg;

	localparam int RATIO_FRAC_BITS = 16;

	localparam logic [63:0] PI4_Q32 = 64'd3373259426;
	localparam logic [63:0] C1_Q32  = 64'd1050978497;
	localparam logic [63:0] C2_Q32  = 64'd284756332;
	localparam int          ANGLE_MAX = 12868;

	// offset applied to the polynomial result
	localparam logic [2:0] BASE_ZERO = 3'd0;
	localparam logic [2:0] BASE_PI   = 3'd1;
	localparam logic [2:0] BASE_NPI  = 3'd2;
	localparam logic [2:0] BASE_HPI  = 3'd3;
	localparam logic [2:0] BASE_NHPI = 3'd4;

	typedef struct packed {
		logic       neg;
		logic [2:0] base;
		logic       zero;
	} a2p_side_t;

	// round a Q.32 constant to nearest into Q.f
	function automatic logic [63:0] to_qf(input logic [63:0] k32, input int f);
		to_qf = (k32 + (64'd1 << (31 - f))) >> (32 - f);
	endfunction

endpackage

@@ sv/a2p_vec_if.sv @@
interface a2p_vec_if;
	logic        valid;
	logic        ready;
	logic [31:0] y_coord;
	logic [31:0] x_coord;

	modport source (output valid, output y_coord, output x_coord, input ready);
	modport sink   (input valid, input y_coord, input x_coord, output ready);
endinterface

@@ sv/a2p_ang_if.sv @@
interface a2p_ang_if;
	logic        valid;
	logic        ready;
	logic [14:0] angle_rad;

	modport source (output valid, output angle_rad, input ready);
	modport sink   (input valid, input angle_rad, output ready);
endinterface

@@ sv/a2p_div_cell.sv @@
module a2p_div_cell import a2p_pkg::*; #(
	parameter int QW    = RATIO_FRAC_BITS + 1,
	parameter bit FIRST = 1'b0
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          up_valid,
	output logic          up_ready,
	input  logic [31:0]   up_rem,
	input  logic [31:0]   up_den,
	input  logic [QW-1:0] up_quot,
	input  a2p_side_t     up_side,
	output logic          dn_valid,
	input  logic          dn_ready,
	output logic [31:0]   dn_rem,
	output logic [31:0]   dn_den,
	output logic [QW-1:0] dn_quot,
	output a2p_side_t     dn_side
);

	logic        v_q;
	logic [32:0] trial;
	logic        ge;
	logic [32:0] diff;

	// first cell compares without shifting: remainder already below 2*den
	assign trial    = FIRST ? {1'b0, up_rem} : {up_rem, 1'b0};
	assign ge       = trial >= {1'b0, up_den};
	assign diff     = trial - {1'b0, up_den};
	assign up_ready = !v_q || dn_ready;
	assign dn_valid = v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (up_ready) begin
			v_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			dn_rem  <= ge ? diff[31:0] : trial[31:0];
			dn_den  <= up_den;
			dn_quot <= {up_quot[QW-2:0], ge};
			dn_side <= up_side;
		end
	end

endmodule

@@ sv/a2p_poly.sv @@
module a2p_poly import a2p_pkg::*; #(
	parameter int F = RATIO_FRAC_BITS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        up_valid,
	output logic        up_ready,
	input  logic [F:0]  up_a,
	input  a2p_side_t   up_side,
	a2p_ang_if.source   ang
);

	localparam int WA = F + 1;
	localparam int PW = 2 * WA;
	localparam int AW = F + 4;
	localparam logic [WA-1:0] PI4  = WA'(to_qf(PI4_Q32, F));
	localparam logic [WA-1:0] C1   = WA'(to_qf(C1_Q32, F));
	localparam logic [WA-1:0] C2   = WA'(to_qf(C2_Q32, F));
	localparam logic [WA-1:0] ONE  = WA'(1) << F;
	localparam logic [PW-1:0] HALF = PW'(1) << (F - 1);
	localparam logic [AW-1:0] AMAX = AW'(ANGLE_MAX);

	logic            v1_q, v2_q, v3_q;
	logic            rd1, rd2, rd3;
	logic [WA-1:0]   a_s1, s_s1, q_s1;
	a2p_side_t       side_s1, side_s2;
	logic [WA:0]     m_s2;
	logic [14:0]     ang_s3;

	logic [PW-1:0]   p_c2, p_q, p_pi, p_qs;
	logic signed [AW-1:0] base_v, term, angle_v;
	logic [AW-1:0]   mag, magr, mags;
	logic            sub;

	assign rd3      = !v3_q || ang.ready;
	assign rd2      = !v2_q || rd3;
	assign rd1      = !v1_q || rd2;
	assign up_ready = rd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
			v3_q <= 1'b0;
		end else begin
			if (rd1) v1_q <= up_valid;
			if (rd2) v2_q <= v1_q;
			if (rd3) v3_q <= v2_q;
		end
	end

	// stage 1: s = c1 + c2*a, q = a*(1-a)
	assign p_c2 = {{WA{1'b0}}, up_a} * {{WA{1'b0}}, C2};
	assign p_q  = {{WA{1'b0}}, up_a} * {{WA{1'b0}}, ONE - up_a};

	always_ff @(posedge clk) begin
		if (rd1 && up_valid) begin
			a_s1    <= up_a;
			s_s1    <= C1 + WA'((p_c2 + HALF) >> F);
			q_s1    <= WA'((p_q + HALF) >> F);
			side_s1 <= up_side;
		end
	end

	// stage 2: m = pi/4*a + q*s
	assign p_pi = {{WA{1'b0}}, a_s1} * {{WA{1'b0}}, PI4};
	assign p_qs = {{WA{1'b0}}, q_s1} * {{WA{1'b0}}, s_s1};

	always_ff @(posedge clk) begin
		if (rd2 && v1_q) begin
			m_s2    <= (WA+1)'((p_pi + HALF) >> F) + (WA+1)'((p_qs + HALF) >> F);
			side_s2 <= side_s1;
		end
	end

	// stage 3: offset, round to Q.12, saturate
	always_comb begin
		case (side_s2.base)
			BASE_PI:   base_v = signed'(AW'(PI4)) <<< 2;
			BASE_NPI:  base_v = -(signed'(AW'(PI4)) <<< 2);
			BASE_HPI:  base_v = signed'(AW'(PI4)) <<< 1;
			BASE_NHPI: base_v = -(signed'(AW'(PI4)) <<< 1);
			default:   base_v = '0;
		endcase
	end

	assign sub     = (side_s2.base == BASE_HPI) || (side_s2.base == BASE_NHPI);
	assign term    = (side_s2.neg ^ sub) ? -signed'(AW'(m_s2)) : signed'(AW'(m_s2));
	assign angle_v = base_v + term;
	assign mag     = angle_v[AW-1] ? AW'(-angle_v) : AW'(angle_v);

	generate
		if (F >= 13) begin : g_rnd_down
			assign magr = (mag + (AW'(1) << (F - 13))) >> (F - 12);
		end else begin : g_rnd_up
			assign magr = mag << (12 - F);
		end
	endgenerate

	assign mags = (magr > AMAX) ? AMAX : magr;

	always_ff @(posedge clk) begin
		if (rd3 && v2_q) begin
			if (side_s2.zero) begin
				ang_s3 <= '0;
			end else begin
				ang_s3 <= angle_v[AW-1] ? 15'(-mags) : 15'(mags);
			end
		end
	end

	assign ang.valid     = v3_q;
	assign ang.angle_rad = ang_s3;

endmodule

@@ sv/atan2_octant_poly_unit.sv @@
// Channel   Role    Word fields                         Accepted when
// vec       sink    y_coord[31:0], x_coord[31:0] Q20.12  vec.valid && vec.ready
// ang       source  angle_rad[14:0] Q3.12 radians        ang.valid && ang.ready
//
// Flow: one vector word per cycle while ang is ready; a word passes through
// one divider cell per quotient bit, then three polynomial stages.
// Reset: arst_n clears every valid flag at once; no clearing pass.
// Stalls: each cell holds its word only while its neighbor is full and stalled,
// so bubbles collapse and a new word enters while a result waits at ang.
module atan2_octant_poly_unit import a2p_pkg::*; #(
	parameter int RATIO_FRAC_BITS_P = RATIO_FRAC_BITS
) (
	input  logic      clk,
	input  logic      arst_n,
	a2p_vec_if.sink   vec,
	a2p_ang_if.source ang
);

	localparam int F  = RATIO_FRAC_BITS_P;
	localparam int QW = F + 1;

	logic          valid_c [0:QW];
	logic          ready_c [0:QW];
	logic [31:0]   rem_c   [0:QW];
	logic [31:0]   den_c   [0:QW];
	logic [QW-1:0] quot_c  [0:QW];
	a2p_side_t     side_c  [0:QW];

	logic        ys, xs, sel_yx;
	logic [31:0] ay, ax;

	// octant decode: magnitudes in 32 bits unsigned keep -2^31 exact
	assign ys     = vec.y_coord[31];
	assign xs     = vec.x_coord[31];
	assign ay     = ys ? (~vec.y_coord + 32'd1) : vec.y_coord;
	assign ax     = xs ? (~vec.x_coord + 32'd1) : vec.x_coord;
	assign sel_yx = ay < ax;

	always_comb begin
		side_c[0].neg  = ys ^ xs;
		side_c[0].zero = (ay == 32'd0) && (ax == 32'd0);
		if (sel_yx) begin
			// |y| below |x|: atan(y/x), shifted by pi on the left half-plane
			rem_c[0] = ay;
			den_c[0] = ax;
			if (!xs) side_c[0].base = BASE_ZERO;
			else if (!ys) side_c[0].base = BASE_PI;
			else side_c[0].base = BASE_NPI;
		end else begin
			// steep side: +-pi/2 minus atan(x/y)
			rem_c[0] = ax;
			den_c[0] = ay;
			side_c[0].base = ys ? BASE_NHPI : BASE_HPI;
		end
	end

	assign valid_c[0] = vec.valid;
	assign quot_c[0]  = '0;
	assign vec.ready  = ready_c[0];

	// restoring divider: one cell per quotient bit, MSB first
	genvar i;
	generate
		for (i = 0; i < QW; i++) begin : g_cell
			a2p_div_cell #(.QW(QW), .FIRST(i == 0)) u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.up_valid (valid_c[i]),
				.up_ready (ready_c[i]),
				.up_rem   (rem_c[i]),
				.up_den   (den_c[i]),
				.up_quot  (quot_c[i]),
				.up_side  (side_c[i]),
				.dn_valid (valid_c[i+1]),
				.dn_ready (ready_c[i+1]),
				.dn_rem   (rem_c[i+1]),
				.dn_den   (den_c[i+1]),
				.dn_quot  (quot_c[i+1]),
				.dn_side  (side_c[i+1])
			);
		end
	endgenerate

	// quotient never exceeds one for a nonzero vector since the smaller magnitude is the numerator
	a2p_poly #(.F(F)) u_poly (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (valid_c[QW]),
		.up_ready (ready_c[QW]),
		.up_a     (quot_c[QW]),
		.up_side  (side_c[QW]),
		.ang      (ang)
	);

endmodule

@@ sv/a2p_checker.sv @@
module a2p_checker import a2p_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        ang_valid,
	input logic        ang_ready,
	input logic [14:0] angle_rad
);

	// a stalled result word holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		ang_valid && !ang_ready |=> ang_valid && $stable(angle_rad))
		else $error("result word changed under stall");

	// angle stays within -pi..pi
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		ang_valid |-> ($signed(angle_rad) <= 15'sd12868) &&
			($signed(angle_rad) >= -15'sd12868))
		else $error("angle out of range");

	// nothing comes out of a freshly reset pipeline
	a_rst: assert property (@(posedge clk)
		$rose(arst_n) |-> !ang_valid)
		else $error("result valid right after reset");

endmodule

bind atan2_octant_poly_unit a2p_checker u_a2p_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.ang_valid (ang.valid),
	.ang_ready (ang.ready),
	.angle_rad (ang.angle_rad)
);

@@ sim/tb_atan2_octant_poly_unit.sv @@
module tb_atan2_octant_poly_unit;
	import a2p_pkg::*;

	// Fraction bits of the ratio; must match the block's default parameter.
	localparam int F = RATIO_FRAC_BITS;
	// Drain after the last result with some margin.
	localparam int DRAIN_CYCLES = F + 16;
	// End the run after this many cycles in a row with no accepted word.
	localparam int STALL_LIMIT = 20000;

	logic clk;
	logic arst_n;

	a2p_vec_if vec ();
	a2p_ang_if ang ();

	atan2_octant_poly_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.vec    (vec.sink),
		.ang    (ang.source)
	);

	// Angles still owed by the block, oldest first.
	logic [14:0] angle_queue[$];
	int unsigned fail_count;
	int unsigned idle_cycles;
	bit rx_stall_en;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Mostly short gaps, now and then a long one, and a fair share of none.
	function automatic int unsigned gap_len();
		int unsigned p;
		p = $urandom_range(0, 99);
		if (p < 45)
			return 0;
		else if (p < 90)
			return $urandom_range(1, 3);
		else
			return $urandom_range(8, 40);
	endfunction

	// Unsigned Q.F multiply, rounded half up back to Q.F.
	function automatic logic [63:0] qmul(input logic [63:0] a, input logic [63:0] b);
		return (a * b + (64'd1 << (F - 1))) >> F;
	endfunction

	// Round a Q.32 constant to Q.F, half up.
	function automatic logic [63:0] k_qf(input logic [63:0] k32);
		return (k32 + (64'd1 << (31 - F))) >> (32 - F);
	endfunction

	// Signed polynomial arctangent of num/den in Q.F; den is nonzero.
	function automatic longint atan_quot(input longint num, input longint den);
		logic [63:0] n, d, a, s, q, m, one;
		bit neg;
		neg = (num < 0) != (den < 0);
		n   = (num < 0) ? -num : num;
		d   = (den < 0) ? -den : den;
		one = 64'd1 << F;
		a   = (n << F) / d;
		if (a > one)
			a = one;
		s = k_qf(C1_Q32) + qmul(k_qf(C2_Q32), a);
		q = qmul(a, one - a);
		m = qmul(k_qf(PI4_Q32), a) + qmul(q, s);
		return neg ? -longint'(m) : longint'(m);
	endfunction

	// Angle of (y, x) as the block should return it, Q3.12 in 15 bits.
	function automatic logic [14:0] vector_angle(input logic [31:0] yv, input logic [31:0] xv);
		longint y, x, pi4, ang_qf, res;
		logic [63:0] mag;
		bit neg;
		y   = longint'(signed'(yv));
		x   = longint'(signed'(xv));
		pi4 = longint'(k_qf(PI4_Q32));
		if (y == 0 && x == 0)
			return '0;
		if (x >= 0) begin
			if (y >= 0)
				ang_qf = (y < x) ? atan_quot(y, x) : 2 * pi4 - atan_quot(x, y);
			else
				ang_qf = (-y < x) ? atan_quot(y, x) : -2 * pi4 - atan_quot(x, y);
		end else begin
			if (y >= 0)
				ang_qf = (y < -x) ? atan_quot(y, x) + 4 * pi4 : 2 * pi4 - atan_quot(x, y);
			else
				ang_qf = (-y < -x) ? atan_quot(y, x) - 4 * pi4 : -2 * pi4 - atan_quot(x, y);
		end
		// Round the magnitude to Q.12 (half away from zero), then clamp to pi.
		neg = ang_qf < 0;
		mag = neg ? -ang_qf : ang_qf;
		mag = (mag + (64'd1 << (F - 13))) >> (F - 12);
		if (mag > ANGLE_MAX)
			mag = ANGLE_MAX;
		res = neg ? -longint'(mag) : longint'(mag);
		return res[14:0];
	endfunction

	// Present one vector word, hold it until accepted, then drop valid for
	// an optional gap. Valid stays high across back-to-back words.
	task automatic send_vector(input logic [31:0] yv, input logic [31:0] xv);
		int unsigned gap;
		vec.valid   <= 1'b1;
		vec.y_coord <= yv;
		vec.x_coord <= xv;
		do
			@(posedge clk);
		while (!vec.ready);
		angle_queue.push_back(vector_angle(yv, xv));
		gap = gap_len();
		if (gap != 0) begin
			vec.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Hold off until the block has returned every angle owed.
	task automatic wait_drained();
		vec.valid <= 1'b0;
		while (angle_queue.size() != 0)
			@(posedge clk);
	endtask

	// Check each accepted angle against the oldest one owed.
	always @(posedge clk) begin
		if (arst_n && ang.valid && ang.ready) begin
			if (angle_queue.size() == 0) begin
				$error("angle_rad: unexpected word, actual %0d", signed'(ang.angle_rad));
				fail_count++;
			end else begin
				if (ang.angle_rad !== angle_queue[0]) begin
					$error("angle_rad: expected %0d, actual %0d",
						signed'(angle_queue[0]), signed'(ang.angle_rad));
					fail_count++;
				end
				void'(angle_queue.pop_front());
			end
		end
	end

	// Randomize ready with runs of stall of mixed length.
	initial begin
		int unsigned n;
		ang.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (rx_stall_en) begin
				n = gap_len();
				if (n != 0) begin
					ang.ready <= 1'b0;
					repeat (n) @(posedge clk);
				end
			end
			ang.ready <= 1'b1;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
	end

	// Watchdog: count cycles in which no word moves on either channel.
	always @(posedge clk) begin
		if ((vec.valid && vec.ready) || (ang.valid && ang.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// Axis points, diagonals of both signs and the most negative values.
	task automatic test_directed();
		logic [31:0] ext[6];
		ext = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'h0000_1000,
			32'hFFFF_F000, 32'h0000_0001};
		send_vector(32'd0, 32'd0);
		send_vector(32'h0000_1000, 32'h0000_1000);
		send_vector(32'h0000_1000, 32'hFFFF_F000);
		send_vector(32'hFFFF_F000, 32'hFFFF_F000);
		send_vector(32'hFFFF_F000, 32'h0000_1000);
		send_vector(32'h8000_0000, 32'h8000_0000);
		send_vector(32'h0000_0000, 32'h8000_0000);
		send_vector(32'hFFFF_FFFF, 32'h8000_0000);
		send_vector(32'h7FFF_FFFF, 32'h8000_0000);
		send_vector(32'h0000_0001, 32'h0000_0000);
		send_vector(32'hFFFF_FFFF, 32'h0000_0000);
		send_vector(32'h0000_0000, 32'hFFFF_FFFF);
		for (int i = 0; i < 6; i++)
			send_vector(ext[i], ext[(i * 5 + 1) % 6]);
	endtask

	// Full-range random vectors with a share of small, near-diagonal and on-axis ones.
	task automatic test_random(input int unsigned count);
		logic [31:0] yv, xv;
		int unsigned mode;
		for (int unsigned i = 0; i < count; i++) begin
			mode = $urandom_range(0, 9);
			yv   = $urandom;
			xv   = $urandom;
			if (mode < 3) begin
				yv = 32'(signed'(yv) >>> $urandom_range(0, 31));
				xv = 32'(signed'(xv) >>> $urandom_range(0, 31));
			end else if (mode < 5) begin
				// near the diagonals, where the octant choice flips
				xv = $urandom_range(0, 1) ? yv : -yv;
				xv = xv + 32'($urandom_range(0, 4)) - 32'd2;
			end else if (mode == 5) begin
				yv = $urandom_range(0, 1) ? 32'd0 : yv;
				xv = (yv == 0) ? xv : 32'd0;
			end
			send_vector(yv, xv);
			if (i == count / 2)
				wait_drained();
		end
	endtask

	initial begin
		fail_count    = 0;
		idle_cycles   = 0;
		rx_stall_en   = 1'b1;
		arst_n        = 1'b0;
		vec.valid     = 1'b0;
		vec.y_coord   = '0;
		vec.x_coord   = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random(600);
		// stretch with full throughput on the result side
		rx_stall_en = 1'b0;
		test_random(150);
		rx_stall_en = 1'b1;
		test_random(500);

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
